// File: src/gta_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the GEMM tile accumulate core.
package gta_pkg;

  typedef enum logic [1:0] {
    OP_WR_A   = 2'd0,
    OP_WR_B   = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  localparam logic [1:0] CFG_K_DEPTH    = 2'd0;
  localparam logic [1:0] CFG_ROWS_VALID = 2'd1;
  localparam logic [1:0] CFG_COLS_VALID = 2'd2;

  localparam logic [7:0] K_DEPTH_RST    = 8'd128;
  localparam logic [3:0] ROWS_VALID_RST = 4'd8;
  localparam logic [4:0] COLS_VALID_RST = 5'd16;

  localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
  localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN    = 32'h7FC0_0000;
  localparam logic [30:0] FP_INF_MAG = 31'h7F80_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ISSUE,
    ST_WAIT,
    ST_FIN,
    ST_FWAIT
  } seq_state_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } fma_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] result;
  } fma_rsp_t;

endpackage

// File: src/gta_panels.sv
`timescale 1ns / 1ps
// A and B panel memories with one write port and registered reads.
module gta_panels #(
  parameter int TILE_ROWS = 8,
  parameter int TILE_COLS = 16,
  parameter int MAX_DEPTH = 128,
  parameter int KW        = 7
) (
  input  logic          clk,
  input  logic          wr_a,
  input  logic          wr_b,
  input  logic [6:0]    wr_k,
  input  logic [2:0]    wr_row,
  input  logic [3:0]    wr_col,
  input  logic [31:0]   wr_data,
  input  logic [KW-1:0] rd_k,
  input  logic [2:0]    rd_row,
  input  logic [3:0]    rd_col,
  output logic [31:0]   rd_a,
  output logic [31:0]   rd_b
);

  localparam int A_DEPTH = MAX_DEPTH * TILE_ROWS;
  localparam int B_DEPTH = MAX_DEPTH * TILE_COLS;
  localparam int AAW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int BAW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

  logic [31:0]    a_mem [0:A_DEPTH-1];
  logic [31:0]    b_mem [0:B_DEPTH-1];
  logic           a_we;
  logic           b_we;
  logic [AAW-1:0] a_waddr;
  logic [BAW-1:0] b_waddr;
  logic [AAW-1:0] a_raddr;
  logic [BAW-1:0] b_raddr;

  assign a_we    = wr_a && (32'(wr_k) < MAX_DEPTH) && (32'(wr_row) < TILE_ROWS);
  assign b_we    = wr_b && (32'(wr_k) < MAX_DEPTH) && (32'(wr_col) < TILE_COLS);
  assign a_waddr = AAW'(32'(wr_k) * TILE_ROWS + 32'(wr_row));
  assign b_waddr = BAW'(32'(wr_k) * TILE_COLS + 32'(wr_col));
  assign a_raddr = AAW'(32'(rd_k) * TILE_ROWS + 32'(rd_row));
  assign b_raddr = BAW'(32'(rd_k) * TILE_COLS + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_waddr] <= wr_data;
    end
    rd_a <= a_mem[a_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[b_waddr] <= wr_data;
    end
    rd_b <= b_mem[b_raddr];
  end

endmodule

// File: src/gta_fma.sv
`timescale 1ns / 1ps
// Six-stage single-precision fused multiply-add unit, round to nearest even.
module gta_fma (
  input  logic               clk,
  input  logic               rst_n,
  input  gta_pkg::fma_req_t  req,
  output gta_pkg::fma_rsp_t  rsp
);

  typedef struct packed {
    logic               sgn;
    logic [23:0]        sig;
    logic signed [11:0] exp;
    logic               zero;
    logic               inf;
    logic               nan;
  } fp_unp_t;

  function automatic logic [4:0] lzc24(input logic [23:0] x);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (x[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc53(input logic [52:0] x);
    logic [5:0] n;
    n = 6'd53;
    for (int i = 0; i < 53; i++) begin
      if (x[i]) n = 6'(52 - i);
    end
    return n;
  endfunction

  function automatic fp_unp_t unpack(input logic [31:0] x);
    fp_unp_t    u;
    logic [23:0] s;
    logic [4:0]  lz;
    logic [7:0]  eff;
    s      = {x[30:23] != 8'd0, x[22:0]};
    lz     = lzc24(s);
    eff    = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    u.sgn  = x[31];
    u.sig  = s << lz;
    u.exp  = $signed({4'd0, eff}) - 12'sd127 - $signed({7'd0, lz});
    u.zero = (s == 24'd0);
    u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    return u;
  endfunction

  logic [5:0] v_r;

  // Unpack stage.
  fp_unp_t            ua, ub, uc;
  logic               sp1;
  logic               p_inf;
  logic               p_zero;
  logic               is_nan;
  logic               spec_nxt;
  logic [31:0]        spec_val_nxt;
  logic [23:0]        s1_asig_r, s1_bsig_r, s1_csig_r;
  logic signed [11:0] s1_aexp_r, s1_bexp_r, s1_cexp_r;
  logic               s1_sp_r, s1_sc_r, s1_cz_r, s1_spec_r;
  logic [31:0]        s1_specv_r;

  always_comb begin
    ua     = unpack(req.a);
    ub     = unpack(req.b);
    uc     = unpack(req.c);
    sp1    = ua.sgn ^ ub.sgn;
    p_inf  = ua.inf | ub.inf;
    p_zero = ua.zero | ub.zero;
    is_nan = ua.nan | ub.nan | uc.nan | (ua.inf & ub.zero) | (ub.inf & ua.zero)
           | (p_inf & uc.inf & (sp1 != uc.sgn));
    spec_nxt     = 1'b1;
    spec_val_nxt = gta_pkg::FP_QNAN;
    if (is_nan) begin
      spec_val_nxt = gta_pkg::FP_QNAN;
    end else if (p_inf) begin
      spec_val_nxt = {sp1, gta_pkg::FP_INF_MAG};
    end else if (uc.inf) begin
      spec_val_nxt = req.c;
    end else if (p_zero) begin
      spec_val_nxt = uc.zero ? {sp1 & uc.sgn, 31'd0} : req.c;
    end else begin
      spec_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    s1_asig_r  <= ua.sig;
    s1_bsig_r  <= ub.sig;
    s1_csig_r  <= uc.sig;
    s1_aexp_r  <= ua.exp;
    s1_bexp_r  <= ub.exp;
    s1_cexp_r  <= uc.exp;
    s1_sp_r    <= sp1;
    s1_sc_r    <= uc.sgn;
    s1_cz_r    <= uc.zero;
    s1_spec_r  <= spec_nxt;
    s1_specv_r <= spec_val_nxt;
  end

  // Multiply stage.
  logic [47:0]        s2_prod_r;
  logic signed [11:0] s2_pexp_r, s2_cexp_r;
  logic [23:0]        s2_csig_r;
  logic               s2_sp_r, s2_sc_r, s2_cz_r, s2_spec_r;
  logic [31:0]        s2_specv_r;

  always_ff @(posedge clk) begin
    s2_prod_r  <= 48'(s1_asig_r) * 48'(s1_bsig_r);
    s2_pexp_r  <= s1_aexp_r + s1_bexp_r;
    s2_cexp_r  <= s1_cexp_r;
    s2_csig_r  <= s1_csig_r;
    s2_sp_r    <= s1_sp_r;
    s2_sc_r    <= s1_sc_r;
    s2_cz_r    <= s1_cz_r;
    s2_spec_r  <= s1_spec_r;
    s2_specv_r <= s1_specv_r;
  end

  // Align and add stage.
  logic [47:0]        pn;
  logic signed [11:0] pe;
  logic               p_big;
  logic signed [11:0] diff;
  logic [5:0]         sh;
  logic [52:0]        big_f, sml_f, sml_sh, sml;
  logic               lost3;
  logic               eff_sub;
  logic [53:0]        sum54, dif54;
  logic               neg;
  logic [52:0]        mag_nxt;
  logic               sign_nxt;
  logic signed [11:0] ebig_nxt;
  logic [52:0]        s3_mag_r;
  logic signed [11:0] s3_ebig_r;
  logic               s3_sign_r, s3_spec_r;
  logic [31:0]        s3_specv_r;

  always_comb begin
    pn      = s2_prod_r[47] ? s2_prod_r : {s2_prod_r[46:0], 1'b0};
    pe      = s2_prod_r[47] ? s2_pexp_r + 12'sd1 : s2_pexp_r;
    p_big   = s2_cz_r || (pe >= s2_cexp_r);
    diff    = p_big ? pe - s2_cexp_r : s2_cexp_r - pe;
    sh      = (diff > 12'sd63) ? 6'd63 : diff[5:0];
    big_f   = p_big ? {1'b0, pn, 4'd0} : {1'b0, s2_csig_r, 28'd0};
    sml_f   = p_big ? {1'b0, s2_csig_r, 28'd0} : {1'b0, pn, 4'd0};
    sml_sh  = sml_f >> sh;
    lost3   = |(sml_f & ~({53{1'b1}} << sh));
    sml     = {sml_sh[52:1], sml_sh[0] | lost3};
    eff_sub = s2_sp_r ^ s2_sc_r;
    sum54   = {1'b0, big_f} + {1'b0, sml};
    dif54   = {1'b0, big_f} - {1'b0, sml};
    neg     = eff_sub & dif54[53];
    if (!eff_sub) begin
      mag_nxt = sum54[52:0];
    end else if (neg) begin
      mag_nxt = ~dif54[52:0] + 53'd1;
    end else begin
      mag_nxt = dif54[52:0];
    end
    sign_nxt = (p_big ? s2_sp_r : s2_sc_r) ^ neg;
    ebig_nxt = p_big ? pe : s2_cexp_r;
  end

  always_ff @(posedge clk) begin
    s3_mag_r   <= mag_nxt;
    s3_ebig_r  <= ebig_nxt;
    s3_sign_r  <= sign_nxt;
    s3_spec_r  <= s2_spec_r;
    s3_specv_r <= s2_specv_r;
  end

  // Leading zero count stage.
  logic [52:0]        s4_mag_r;
  logic [5:0]         s4_lz_r;
  logic signed [11:0] s4_ebig_r;
  logic               s4_sign_r, s4_zero_r, s4_spec_r;
  logic [31:0]        s4_specv_r;

  always_ff @(posedge clk) begin
    s4_mag_r   <= s3_mag_r;
    s4_lz_r    <= lzc53(s3_mag_r);
    s4_zero_r  <= (s3_mag_r == 53'd0);
    s4_ebig_r  <= s3_ebig_r;
    s4_sign_r  <= s3_sign_r;
    s4_spec_r  <= s3_spec_r;
    s4_specv_r <= s3_specv_r;
  end

  // Normalise stage.
  logic signed [11:0] er_nxt;
  logic signed [11:0] den_t;
  logic [4:0]         den_nxt;
  logic [52:0]        s5_n_r;
  logic signed [11:0] s5_er_r;
  logic [4:0]         s5_den_r;
  logic               s5_sign_r, s5_zero_r, s5_spec_r;
  logic [31:0]        s5_specv_r;

  always_comb begin
    er_nxt = s4_ebig_r + 12'sd1 - $signed({6'd0, s4_lz_r});
    den_t  = -12'sd126 - er_nxt;
    if (er_nxt >= -12'sd126) begin
      den_nxt = 5'd0;
    end else if (den_t > 12'sd31) begin
      den_nxt = 5'd31;
    end else begin
      den_nxt = den_t[4:0];
    end
  end

  always_ff @(posedge clk) begin
    s5_n_r     <= s4_mag_r << s4_lz_r;
    s5_er_r    <= er_nxt;
    s5_den_r   <= den_nxt;
    s5_sign_r  <= s4_sign_r;
    s5_zero_r  <= s4_zero_r;
    s5_spec_r  <= s4_spec_r;
    s5_specv_r <= s4_specv_r;
  end

  // Round and pack stage.
  logic [52:0]        ns;
  logic               lost6;
  logic [23:0]        mant;
  logic               rnd_up;
  logic [24:0]        mr;
  logic signed [11:0] er_b;
  logic [10:0]        base;
  logic [33:0]        mag34;
  logic [31:0]        res_nxt;
  logic [31:0]        res_r;

  always_comb begin
    ns     = s5_n_r >> s5_den_r;
    lost6  = |(s5_n_r & ~({53{1'b1}} << s5_den_r));
    mant   = ns[52:29];
    rnd_up = ns[28] & ((|ns[27:0]) | lost6 | mant[0]);
    mr     = {1'b0, mant} + {24'd0, rnd_up};
    er_b   = s5_er_r + 12'sd126;
    base   = (s5_den_r == 5'd0) ? er_b[10:0] : 11'd0;
    mag34  = {base, 23'd0} + {9'd0, mr};
    if (s5_spec_r) begin
      res_nxt = s5_specv_r;
    end else if (s5_zero_r) begin
      res_nxt = gta_pkg::FP_ZERO;
    end else if (mag34 >= {3'd0, gta_pkg::FP_INF_MAG}) begin
      res_nxt = {s5_sign_r, gta_pkg::FP_INF_MAG};
    end else begin
      res_nxt = {s5_sign_r, mag34[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 6'd0;
    end else begin
      v_r <= {v_r[4:0], req.valid};
    end
  end

  assign rsp.valid  = v_r[5];
  assign rsp.result = res_r;

endmodule

// File: src/gemm_tile_accumulate_core.sv
`timescale 1ns / 1ps
// Top level: configuration, panel loads and the update sequencer.
// An update of depth d = min(k_depth, MAX_DEPTH) strobes its result when busy also drops:
// each k step is a panel read, an issue and a wait on the multiply-add unit, then the old
// C value is added in a final pass through the same unit. The receiver cannot stall the
// result. Reset is synchronous and active low: it restores the configuration defaults and
// idles the sequencer; the panels are not cleared.
module gemm_tile_accumulate_core #(
  parameter int TILE_ROWS = 8,
  parameter int TILE_COLS = 16,
  parameter int MAX_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [6:0]  in_k_index,
  input  logic [2:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_row,
  output logic [3:0]  out_col,
  output logic [31:0] out_sum_value,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int KW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = ((KW > 8) ? KW : 8) + 1;

  gta_pkg::seq_state_t state_r, state_nxt;
  logic [7:0]          k_depth_r;
  logic [3:0]          rows_valid_r;
  logic [4:0]          cols_valid_r;
  logic [KW-1:0]       k_r, k_nxt;
  logic [31:0]         acc_r, acc_nxt;
  logic [31:0]         c_r, c_nxt;
  logic [2:0]          row_r, row_nxt;
  logic [3:0]          col_r, col_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_sum_r, out_sum_nxt;
  logic [2:0]          out_row_r, out_row_nxt;
  logic [3:0]          out_col_r, out_col_nxt;
  logic                accept;
  logic                in_area;
  logic                upd_go;
  logic [CW-1:0]       depth;
  logic                last_k;
  logic [31:0]         rd_a, rd_b;
  gta_pkg::fma_req_t   req;
  gta_pkg::fma_rsp_t   rsp;

  assign busy    = (state_r != gta_pkg::ST_IDLE);
  assign accept  = start && !busy;
  assign in_area = ({1'b0, in_row} < rows_valid_r) && (32'(in_row) < TILE_ROWS)
                && ({1'b0, in_col} < cols_valid_r) && (32'(in_col) < TILE_COLS);
  assign upd_go  = accept && (in_operation == gta_pkg::OP_UPDATE) && in_area;
  assign depth   = (32'(k_depth_r) > MAX_DEPTH) ? CW'(MAX_DEPTH) : CW'(k_depth_r);
  assign last_k  = (CW'(k_r) + CW'(1)) == depth;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_depth_r    <= gta_pkg::K_DEPTH_RST;
      rows_valid_r <= gta_pkg::ROWS_VALID_RST;
      cols_valid_r <= gta_pkg::COLS_VALID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gta_pkg::CFG_K_DEPTH:    k_depth_r    <= cfg_wdata;
        gta_pkg::CFG_ROWS_VALID: rows_valid_r <= cfg_wdata[3:0];
        gta_pkg::CFG_COLS_VALID: cols_valid_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  gta_panels #(
    .TILE_ROWS (TILE_ROWS),
    .TILE_COLS (TILE_COLS),
    .MAX_DEPTH (MAX_DEPTH),
    .KW        (KW)
  ) u_panels (
    .clk     (clk),
    .wr_a    (accept && (in_operation == gta_pkg::OP_WR_A)),
    .wr_b    (accept && (in_operation == gta_pkg::OP_WR_B)),
    .wr_k    (in_k_index),
    .wr_row  (in_row),
    .wr_col  (in_col),
    .wr_data (in_value),
    .rd_k    (k_r),
    .rd_row  (row_r),
    .rd_col  (col_r),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  gta_fma u_fma (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    c_nxt         = c_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    out_valid_nxt = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    req.valid     = 1'b0;
    req.a         = rd_a;
    req.b         = rd_b;
    req.c         = acc_r;
    case (state_r)
      gta_pkg::ST_IDLE: begin
        if (upd_go) begin
          row_nxt   = in_row;
          col_nxt   = in_col;
          c_nxt     = in_value;
          k_nxt     = '0;
          acc_nxt   = gta_pkg::FP_ZERO;
          state_nxt = (depth == '0) ? gta_pkg::ST_FIN : gta_pkg::ST_READ;
        end
      end
      gta_pkg::ST_READ: begin
        state_nxt = gta_pkg::ST_ISSUE;
      end
      gta_pkg::ST_ISSUE: begin
        req.valid = 1'b1;
        state_nxt = gta_pkg::ST_WAIT;
      end
      gta_pkg::ST_WAIT: begin
        if (rsp.valid) begin
          acc_nxt = rsp.result;
          if (last_k) begin
            state_nxt = gta_pkg::ST_FIN;
          end else begin
            k_nxt     = k_r + KW'(1);
            state_nxt = gta_pkg::ST_READ;
          end
        end
      end
      gta_pkg::ST_FIN: begin
        req.valid = 1'b1;
        req.a     = gta_pkg::FP_ONE;
        req.b     = acc_r;
        req.c     = c_r;
        state_nxt = gta_pkg::ST_FWAIT;
      end
      gta_pkg::ST_FWAIT: begin
        if (rsp.valid) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = rsp.result;
          out_row_nxt   = row_r;
          out_col_nxt   = col_r;
          state_nxt     = gta_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gta_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gta_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    c_r       <= c_nxt;
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    out_sum_r <= out_sum_nxt;
    out_row_r <= out_row_nxt;
    out_col_r <= out_col_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_sum_value = out_sum_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;

`ifndef SYNTHESIS
  a_out_after_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == gta_pkg::ST_FWAIT))
    else $error("Result beat without a final pass.");

  a_rsp_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.valid |-> (state_r == gta_pkg::ST_WAIT || state_r == gta_pkg::ST_FWAIT))
    else $error("Multiply-add response outside a wait state.");

  a_update_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    upd_go |=> busy)
    else $error("Accepted update did not start the sequencer.");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Result beat repeated.");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the GEMM tile accumulate core: panel loads and C updates.
module tb_top;

  localparam int ROWS = 8;
  localparam int COLS = 16;
  localparam int DEPTH = 128;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 8 * DEPTH + 40;

  typedef struct {
    logic [1:0]  op;
    logic [6:0]  k;
    logic [2:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
  } beat_t;

  typedef struct {
    logic [2:0]  row;
    logic [3:0]  col;
    logic [31:0] sum;
  } tile_sum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_operation = '0;
  logic [6:0]  in_k_index = '0;
  logic [2:0]  in_row = '0;
  logic [3:0]  in_col = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic [2:0]  out_row;
  logic [3:0]  out_col;
  logic [31:0] out_sum_value;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;

  beat_t       pending[$];
  tile_sum_t   sums_due[$];
  beat_t       cur;
  int          idle_left = 0;
  bit          no_gaps = 1'b0;
  int          errors = 0;
  int          quiet = 0;

  logic [31:0] a_mem [DEPTH][ROWS];
  logic [31:0] b_mem [DEPTH][COLS];
  logic [7:0]  k_depth_q = gta_pkg::K_DEPTH_RST;
  logic [3:0]  rows_valid_q = gta_pkg::ROWS_VALID_RST;
  logic [4:0]  cols_valid_q = gta_pkg::COLS_VALID_RST;

  bit          a_loaded [DEPTH][ROWS];
  bit          b_loaded [DEPTH][COLS];
  int          gen_depth;
  int          gen_rows;
  int          gen_cols;

  gemm_tile_accumulate_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic real sp_to_real(logic [31:0] f);
    logic [63:0] d;
    logic [23:0] m;
    int          ex;
    m = {1'b0, f[22:0]};
    if (f[30:23] == 8'hFF) begin
      d = {f[31], 11'h7FF, f[22:0], 29'b0};
    end else if (f[30:23] == 8'h00) begin
      if (m == 0) begin
        d = {f[31], 63'b0};
      end else begin
        ex = -126;
        while (!m[23]) begin
          m = m << 1;
          ex--;
        end
        d = {f[31], 11'(ex + 1023), m[22:0], 29'b0};
      end
    end else begin
      d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0};
    end
    return $bitstoreal(d);
  endfunction

  function automatic logic [31:0] real_to_sp(logic [63:0] d);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] mag;
    int          e;
    int          sh;
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? gta_pkg::FP_QNAN : {d[63], gta_pkg::FP_INF_MAG};
    end
    if (d[62:52] == 11'h000) return {d[63], 31'b0};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return {d[63], gta_pkg::FP_INF_MAG};
    m = {11'b0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) sh = 60;
    q = m >> sh;
    rem = m & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 1;
    if (e >= -126) mag = (32'(e + 127) << 23) + q[31:0] - 32'h0080_0000;
    else mag = q[31:0];
    return {d[63], mag[30:0]};
  endfunction

  // Single rounding: the sum of an exact product and the addend is rounded
  // to odd in double precision before the final rounding to single.
  function automatic logic [31:0] fused_madd(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    real         p;
    real         cd;
    real         s;
    real         bb;
    real         err;
    logic [63:0] bits;
    p = sp_to_real(a) * sp_to_real(b);
    cd = sp_to_real(c);
    s = p + cd;
    bits = $realtobits(s);
    if (bits[62:52] != 11'h7FF) begin
      bb = s - p;
      err = (p - (s - bb)) + (cd - bb);
      if (err != 0.0 && !bits[0]) begin
        if ((err > 0.0) == (s > 0.0)) bits = bits + 1;
        else bits = bits - 1;
      end
    end
    return real_to_sp(bits);
  endfunction

  task automatic predict_beat(beat_t b);
    tile_sum_t   t;
    logic [31:0] acc;
    int          depth;
    case (b.op)
      gta_pkg::OP_WR_A:   a_mem[b.k][b.row] = b.value;
      gta_pkg::OP_WR_B:   b_mem[b.k][b.col] = b.value;
      gta_pkg::OP_UPDATE: begin
        if (b.row < rows_valid_q && b.col < cols_valid_q) begin
          depth = (k_depth_q > DEPTH) ? DEPTH : k_depth_q;
          acc = gta_pkg::FP_ZERO;
          for (int k = 0; k < depth; k++) begin
            acc = fused_madd(a_mem[k][b.row], b_mem[k][b.col], acc);
          end
          acc = fused_madd(gta_pkg::FP_ONE, acc, b.value);
          if (acc[30:23] == 8'hFF && acc[22:0] != 0) acc = gta_pkg::FP_QNAN;
          t.row = b.row;
          t.col = b.col;
          t.sum = acc;
          sums_due.push_back(t);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    bit fire;
    if (!rst_n) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        predict_beat(cur);
        idle_left = no_gaps ? 0 : $urandom_range(0, 19);
      end
      if (fire || !start) begin
        if (idle_left == 0 && pending.size() != 0) begin
          cur = pending.pop_front();
          in_operation <= cur.op;
          in_k_index <= cur.k;
          in_row <= cur.row;
          in_col <= cur.col;
          in_value <= cur.value;
          start <= 1'b1;
        end else begin
          if (idle_left > 0) idle_left--;
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tile_sum_t t;
    if (rst_n && out_valid) begin
      if (sums_due.size() == 0) begin
        report("unexpected result", out_sum_value, 32'h0);
      end else begin
        t = sums_due.pop_front();
        if (out_row !== t.row) report("out_row", 32'(out_row), 32'(t.row));
        if (out_col !== t.col) report("out_col", 32'(out_col), 32'(t.col));
        if (out_sum_value !== t.sum) report("out_sum_value", out_sum_value, t.sum);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_fp();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 7))
      0: ;
      1: v[30:23] = 8'h00;
      2: v = {v[31], 31'b0};
      3: v = {v[31], gta_pkg::FP_INF_MAG};
      default: v[30:23] = 8'($urandom_range(112, 140));
    endcase
    return v;
  endfunction

  task automatic push_beat(logic [1:0] op, int k, int row, int col, logic [31:0] value);
    beat_t b;
    b.op = op;
    b.k = 7'(k);
    b.row = 3'(row);
    b.col = 4'(col);
    b.value = value;
    if (op == gta_pkg::OP_WR_A) a_loaded[b.k][b.row] = 1'b1;
    if (op == gta_pkg::OP_WR_B) b_loaded[b.k][b.col] = 1'b1;
    pending.push_back(b);
  endtask

  // Loads any panel entries the update would read that are still unwritten.
  task automatic push_update(int row, int col, logic [31:0] c);
    if (row < gen_rows && col < gen_cols) begin
      for (int k = 0; k < gen_depth; k++) begin
        if (!a_loaded[k][row]) push_beat(gta_pkg::OP_WR_A, k, row, $urandom, rand_fp());
        if (!b_loaded[k][col]) push_beat(gta_pkg::OP_WR_B, k, $urandom, col, rand_fp());
      end
    end
    push_beat(gta_pkg::OP_UPDATE, $urandom, row, col, c);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gta_pkg::CFG_K_DEPTH:    k_depth_q = data;
      gta_pkg::CFG_ROWS_VALID: rows_valid_q = data[3:0];
      gta_pkg::CFG_COLS_VALID: cols_valid_q = data[4:0];
      default: ;
    endcase
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending.size() != 0 || start || sums_due.size() != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_tile(int kd, int rv, int cv);
    settle();
    write_reg(gta_pkg::CFG_K_DEPTH, 8'(kd));
    write_reg(gta_pkg::CFG_ROWS_VALID, 8'(rv));
    write_reg(gta_pkg::CFG_COLS_VALID, 8'(cv));
    gen_depth = (kd > DEPTH) ? DEPTH : kd;
    gen_rows = (rv > ROWS) ? ROWS : rv;
    gen_cols = (cv > COLS) ? COLS : cv;
    no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  task automatic random_phase(int kd, int rv, int cv, int n);
    int pick;
    set_tile(kd, rv, cv);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12 && gen_rows > 0 && gen_cols > 0)
        push_update($urandom_range(0, gen_rows - 1), $urandom_range(0, gen_cols - 1), rand_fp());
      else if (pick < 15)
        push_update($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1), rand_fp());
      else if (pick < 18)
        push_beat(2'($urandom_range(0, 1)), $urandom_range(0, DEPTH - 1), $urandom,
                  $urandom, rand_fp());
      else
        push_beat(OP_SPARE, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    set_tile(2, 8, 16);
    push_beat(gta_pkg::OP_WR_A, 0, 0, 0, {1'b0, gta_pkg::FP_INF_MAG});
    push_beat(gta_pkg::OP_WR_B, 0, 0, 0, gta_pkg::FP_ZERO);
    push_beat(gta_pkg::OP_WR_A, 1, 0, 0, gta_pkg::FP_ONE);
    push_beat(gta_pkg::OP_WR_B, 1, 0, 0, gta_pkg::FP_ONE);
    push_update(0, 0, gta_pkg::FP_ONE);
    push_beat(gta_pkg::OP_WR_A, 0, 7, 0, 32'h7F7F_FFFF);
    push_beat(gta_pkg::OP_WR_A, 1, 7, 0, 32'hFF7F_FFFF);
    push_beat(gta_pkg::OP_WR_B, 0, 0, 15, 32'h7F7F_FFFF);
    push_beat(gta_pkg::OP_WR_B, 1, 0, 15, 32'h7F7F_FFFF);
    push_update(7, 15, 32'hFF80_0000);
    push_beat(gta_pkg::OP_WR_A, 0, 1, 0, 32'h0000_0001);
    push_beat(gta_pkg::OP_WR_A, 1, 1, 0, 32'h8000_0003);
    push_beat(gta_pkg::OP_WR_B, 0, 0, 1, 32'h3F00_0000);
    push_beat(gta_pkg::OP_WR_B, 1, 0, 1, 32'h4040_0000);
    push_update(1, 1, 32'h8000_0000);
    push_update(1, 15, 32'hFFFF_FFFF);
    push_update(7, 1, 32'h7F80_0001);
    push_beat(OP_SPARE, 127, 7, 15, 32'hFFFF_FFFF);
    push_beat(OP_SPARE, 0, 0, 0, 32'h0);

    random_phase(1, 8, 16, 50);
    random_phase(0, 4, 5, 30);
    random_phase(3, 8, 16, 50);
    random_phase(128, 1, 1, 4);
    random_phase(8, 15, 31, 40);
    random_phase(255, 1, 1, 3);
    random_phase(5, 0, 0, 15);
    random_phase(4, 3, 20, 40);
    settle();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
